FILE: sv/min_max_normaliser_core_macros.svh
// assertion macros for the min-max normaliser checker
// no dependencies
`ifndef MIN_MAX_NORMALISER_CORE_MACROS_SVH
`define MIN_MAX_NORMALISER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define MMN_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmn assertion failed");

// next-cycle implication, off during reset
`define MMN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmn assertion failed");

// next-cycle implication, checked through reset as well
`define MMN_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("mmn assertion failed");

`endif

FILE: sv/mmn_pkg.sv
// types, constants and request codes for the min-max normaliser
// no dependencies
package mmn_pkg;

  localparam int COLUMNS   = 16;
  localparam int COL_IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int REQ_W     = 2;
  localparam int COL_W     = 4;
  localparam int SAMPLE_W  = 32;
  localparam int SCALED_W  = 15;

  localparam int QUOT_W = 16;
  localparam int QCNT_W = $clog2(QUOT_W);
  localparam int DVS_W  = SAMPLE_W + 4;
  localparam int DIV_W  = DVS_W + QUOT_W;

  localparam logic [SCALED_W-1:0] TENTH_Q15 = SCALED_W'(3277);
  localparam logic [SCALED_W-1:0] Q15_MAX   = '1;

  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR     = 2'd0,
    REQ_OBSERVE   = 2'd1,
    REQ_NORMALISE = 2'd2
  } req_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_PREP,
    S_DIVIDE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0]           req_type;
    logic [COL_W-1:0]           column;
    logic signed [SAMPLE_W-1:0] sample_value;
  } req_t;

  typedef struct packed {
    logic [SCALED_W-1:0] scaled_value;
    logic [COL_W-1:0]    out_column;
    logic                flat_column;
  } rsp_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_stat_t;

endpackage

FILE: sv/mmn_divider.sv
// restoring divider, one quotient bit per cycle, msb first
// depends on mmn_pkg
module mmn_divider (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [mmn_pkg::DIV_W-1:0] dividend,
  input  logic [mmn_pkg::DVS_W-1:0] divisor,
  output mmn_pkg::div_stat_t       stat
);
  import mmn_pkg::*;

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  dsr;
  logic [QUOT_W-1:0] quot;
  logic [QCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic              fits;

  assign fits = (rem >= dsr);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + QCNT_W'(1);
        if (cnt == QCNT_W'(QUOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= dividend;
      dsr  <= DIV_W'({divisor, {(QUOT_W-1){1'b0}}});
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsr;
      end
      quot <= {quot[QUOT_W-2:0], fits};
      dsr  <= dsr >> 1;
    end
  end

  assign stat.done = done;
  assign stat.quot = quot;

endmodule

FILE: sv/min_max_normaliser_core.sv
// per-column min-max scaling; depends on mmn_pkg and mmn_divider
// clear and observe: accepted in S_IDLE, handled in S_FETCH, then ready again in S_IDLE
// normalise: S_FETCH, S_PREP, S_DIVIDE, then S_DONE waits for a free output slot;
//   S_DIVIDE runs the restoring divider, one quotient bit per cycle
// flat or unseen column: S_FETCH, S_DONE; below range: S_FETCH, S_PREP, S_DONE
// rst (synchronous) clears the sequencer, rsp_valid and all seen bits
module min_max_normaliser_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  mmn_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output mmn_pkg::rsp_t rsp
);
  import mmn_pkg::*;

  state_t state, state_next;
  req_t   cur;

  logic signed [SAMPLE_W-1:0] col_min [COLUMNS];
  logic signed [SAMPLE_W-1:0] col_max [COLUMNS];
  logic [COLUMNS-1:0]         seen;

  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W-1:0]        span;
  logic [SCALED_W-1:0]        res_val, res_val_next;
  logic                       res_flat, res_flat_next;

  logic [COL_IDX_W-1:0]       col_idx;
  logic                       col_ok;
  logic signed [SAMPLE_W-1:0] sel_min, sel_max, x;
  logic                       sel_seen;
  logic signed [SAMPLE_W-1:0] obs_min, obs_max;
  logic signed [SAMPLE_W+4:0] tval;

  logic seen_clr, obs_wr, fetch_ld, res_ld, div_start, rsp_ld;

  logic [DIV_W-1:0] dividend;
  logic [DVS_W-1:0] divisor;
  div_stat_t        div_stat;

  assign req_ready = (state == S_IDLE);

  assign col_idx  = COL_IDX_W'(cur.column);
  assign col_ok   = (32'(cur.column) < COLUMNS);
  assign x        = $signed(cur.sample_value);
  assign sel_min  = col_min[col_idx];
  assign sel_max  = col_max[col_idx];
  assign sel_seen = seen[col_idx];

  assign obs_min = (!sel_seen || x < sel_min) ? x : sel_min;
  assign obs_max = (!sel_seen || x > sel_max) ? x : sel_max;

  // 8*d + s
  assign tval = $signed({diff[SAMPLE_W], diff, 3'b000}) + $signed({5'b00000, span});

  // 32768*(8d+s) + 5s over 10s
  assign dividend = {1'b0, tval[SAMPLE_W+3:0], 15'd0}
                  + DIV_W'({span, 2'b00}) + DIV_W'(span);
  assign divisor  = DVS_W'({span, 3'b000}) + DVS_W'({span, 1'b0});

  mmn_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    seen_clr      = 1'b0;
    obs_wr        = 1'b0;
    fetch_ld      = 1'b0;
    res_ld        = 1'b0;
    div_start     = 1'b0;
    rsp_ld        = 1'b0;
    res_val_next  = TENTH_Q15;
    res_flat_next = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        state_next = S_IDLE;
        case (cur.req_type)
          REQ_CLEAR: begin
            seen_clr = 1'b1;
          end
          REQ_OBSERVE: begin
            obs_wr = col_ok;
          end
          REQ_NORMALISE: begin
            if (!col_ok || !sel_seen || sel_max == sel_min) begin
              res_ld     = 1'b1;
              state_next = S_DONE;
            end else begin
              fetch_ld   = 1'b1;
              state_next = S_PREP;
            end
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end
      S_PREP: begin
        if (tval[SAMPLE_W+4]) begin
          res_ld        = 1'b1;
          res_val_next  = '0;
          res_flat_next = 1'b0;
          state_next    = S_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = S_DIVIDE;
        end
      end
      S_DIVIDE: begin
        res_flat_next = 1'b0;
        res_val_next  = div_stat.quot[QUOT_W-1] ? Q15_MAX
                                                : div_stat.quot[SCALED_W-1:0];
        if (div_stat.done) begin
          res_ld     = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_ld     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (seen_clr) begin
        seen <= '0;
      end else if (obs_wr) begin
        seen[col_idx] <= 1'b1;
      end
      if (rsp_ld) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cur <= req;
    end
    if (obs_wr) begin
      col_min[col_idx] <= obs_min;
      col_max[col_idx] <= obs_max;
    end
    if (fetch_ld) begin
      diff <= $signed({x[SAMPLE_W-1], x}) - $signed({sel_min[SAMPLE_W-1], sel_min});
      span <= sel_max - sel_min;
    end
    if (res_ld) begin
      res_val  <= res_val_next;
      res_flat <= res_flat_next;
    end
    if (rsp_ld) begin
      rsp.scaled_value <= res_val;
      rsp.out_column   <= cur.column;
      rsp.flat_column  <= res_flat;
    end
  end

endmodule

FILE: sv/mmn_checker.sv
// port-level checks for min_max_normaliser_core, bound into min_max_normaliser_core
// depends on mmn_pkg and min_max_normaliser_core_macros.svh
`include "min_max_normaliser_core_macros.svh"

module mmn_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input mmn_pkg::rsp_t rsp
);
  import mmn_pkg::*;

  logic req_acc, rsp_stall;

  assign req_acc   = req_valid && req_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;

  // ready is low in the cycle after each accepted request
  `MMN_ASSERT_NEXT(busy_after_accept, clk, rst, req_acc, !req_ready)

  // flat or unseen columns always give the tenth
  `MMN_ASSERT_IMPL(flat_gives_tenth, clk, rst, rsp_valid && rsp.flat_column,
    rsp.scaled_value == TENTH_Q15)

  // stalled result holds
  `MMN_ASSERT_NEXT(rsp_holds, clk, rst, rsp_stall, rsp_valid && $stable(rsp))

  // reset empties the output register
  `MMN_ASSERT_NEXT_ALWAYS(rsp_empty_after_reset, clk, rst, !rsp_valid && req_ready)

endmodule

bind min_max_normaliser_core mmn_checker u_mmn_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
